/* design/cnm_pkg.sv */
`timescale 1ns / 1ps
package cnm_pkg;

   // number of message fields on the bus and the edges that take part
   localparam int MsgCount = 12;
   localparam int CHECK_DEGREE = 12;
   localparam int EdgeCount = (CHECK_DEGREE > MsgCount) ? MsgCount : CHECK_DEGREE;

   localparam int MsgWidth = 8;
   localparam int MagWidth = 7;
   localparam int DataWidth = MsgCount * MsgWidth;

   // magnitude scaling m - (m >> 3) - (m >> 4)
   localparam int ScaleShiftA = 3;
   localparam int ScaleShiftB = 4;

   // largest scaled magnitude, also the value of a missing minimum
   localparam logic [MagWidth-1:0] MagSat = MagWidth'(105);

   // first merge level works on groups of four magnitudes
   localparam int GroupSize = 4;
   localparam int GroupCount = MsgCount / GroupSize;

   typedef logic signed [MsgWidth-1:0] msg_type;
   typedef logic [MagWidth-1:0] mag_type;

   typedef struct packed {
      mag_type min1;
      mag_type min2;
   } min_pair_type;

   typedef struct packed {
      mag_type [MsgCount-1:0] mag;
      logic [MsgCount-1:0]    neg;
   } edge_set_type;

   typedef struct packed {
      edge_set_type edges;
      min_pair_type mins;
      logic         parity;
   } node_type;

   function automatic min_pair_type sort_two(mag_type a, mag_type b);
      min_pair_type r;
      if (a <= b) begin
         r.min1 = a;
         r.min2 = b;
      end else begin
         r.min1 = b;
         r.min2 = a;
      end
      return r;
   endfunction

   // two smallest of two sorted pairs, repeated values kept apart
   function automatic min_pair_type merge_pairs(min_pair_type a, min_pair_type b);
      min_pair_type r;
      if (a.min1 <= b.min1) begin
         r.min1 = a.min1;
         r.min2 = (a.min2 <= b.min1) ? a.min2 : b.min1;
      end else begin
         r.min1 = b.min1;
         r.min2 = (b.min2 <= a.min1) ? b.min2 : a.min1;
      end
      return r;
   endfunction

endpackage

/* design/cnm_scale.sv */
`timescale 1ns / 1ps
module cnm_scale
   import cnm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  msg_type [MsgCount-1:0] in_msg,
   output logic                   out_valid,
   input  logic                   out_ready,
   output edge_set_type           out_set
);

   logic         valid_ff;
   logic         valid_in;
   edge_set_type set_ff;
   edge_set_type set_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic [MsgWidth-1:0] m;
      logic [MsgWidth-1:0] s;
      set_in = set_ff;
      for (int i = 0; i < MsgCount; i++) begin
         m = in_msg[i][MsgWidth-1] ? MsgWidth'(-in_msg[i]) : MsgWidth'(in_msg[i]);
         s = m - (m >> ScaleShiftA) - (m >> ScaleShiftB);
         if (i < EdgeCount) begin
            set_in.mag[i] = s[MagWidth-1:0];
            set_in.neg[i] = in_msg[i][MsgWidth-1];
         end else begin
            // idle edges never win the minimum and add no sign
            set_in.mag[i] = MagSat;
            set_in.neg[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         set_ff <= set_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_set   = set_ff;

endmodule

/* design/cnm_merge.sv */
`timescale 1ns / 1ps
module cnm_merge
   import cnm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  edge_set_type in_set,
   output logic         out_valid,
   input  logic         out_ready,
   output node_type     out_node
);

   // first stage: two smallest of each group of four
   logic                              grp_valid_ff;
   logic                              grp_valid_in;
   logic                              grp_ready;
   min_pair_type [GroupCount-1:0]     grp_ff;
   min_pair_type [GroupCount-1:0]     grp_in;
   edge_set_type                      grp_set_ff;

   // second stage: merge of the groups and the sign parity
   logic         node_valid_ff;
   logic         node_valid_in;
   node_type     node_ff;
   node_type     node_in;

   assign grp_ready    = !node_valid_ff || out_ready;
   assign in_ready     = !grp_valid_ff || grp_ready;
   assign grp_valid_in = in_ready ? in_valid : grp_valid_ff;
   assign node_valid_in = grp_ready ? grp_valid_ff : node_valid_ff;

   always_comb begin
      for (int g = 0; g < GroupCount; g++) begin
         grp_in[g] = merge_pairs(
            sort_two(in_set.mag[g*GroupSize],     in_set.mag[g*GroupSize + 1]),
            sort_two(in_set.mag[g*GroupSize + 2], in_set.mag[g*GroupSize + 3]));
      end
   end

   always_comb begin
      min_pair_type acc;
      acc = grp_ff[0];
      for (int g = 1; g < GroupCount; g++) begin
         acc = merge_pairs(acc, grp_ff[g]);
      end
      node_in.edges  = grp_set_ff;
      node_in.mins   = acc;
      node_in.parity = ^grp_set_ff.neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff  <= 1'b0;
         node_valid_ff <= 1'b0;
      end else begin
         grp_valid_ff  <= grp_valid_in;
         node_valid_ff <= node_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         grp_ff     <= grp_in;
         grp_set_ff <= in_set;
      end
      if (grp_ready && grp_valid_ff) begin
         node_ff <= node_in;
      end
   end

   assign out_valid = node_valid_ff;
   assign out_node  = node_ff;

endmodule

/* design/cnm_select.sv */
`timescale 1ns / 1ps
module cnm_select
   import cnm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  node_type               in_node,
   output logic                   out_valid,
   input  logic                   out_ready,
   output msg_type [MsgCount-1:0] out_msg
);

   logic                   valid_ff;
   logic                   valid_in;
   msg_type [MsgCount-1:0] msg_ff;
   msg_type [MsgCount-1:0] msg_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      mag_type             m;
      logic [MsgWidth-1:0] ext;
      logic                negative;
      for (int i = 0; i < MsgCount; i++) begin
         m = (in_node.edges.mag[i] == in_node.mins.min1) ? in_node.mins.min2
                                                         : in_node.mins.min1;
         ext = {1'b0, m};
         // own sign taken back out of the full parity
         negative = in_node.parity ^ in_node.edges.neg[i];
         if (i < EdgeCount) begin
            msg_in[i] = negative ? msg_type'(~ext + 1'b1) : msg_type'(ext);
         end else begin
            msg_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         msg_ff <= msg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_msg   = msg_ff;

endmodule

/* design/ldpc_check_node_min_sum.sv */
`timescale 1ns / 1ps
// normalized min-sum check-node update, one check node of degree 12 per word
// req channel: one word carries the twelve signed 8-bit variable-to-check
//    messages, msg 0 in the lowest byte
// rsp channel: one word carries the twelve check-to-variable messages in the
//    same byte order; edges beyond the node degree read as zero
// each magnitude is scaled by about 0.8125 before the search for the two
//    smallest; an edge holding the smallest gets the second smallest, and
//    its sign is the product of the other signs
// pipeline of four register stages: scaling, four-wide min groups, final
//    merge with sign parity, and output select held in the rsp register
// throughput: one word per cycle while rsp_tready does not stall, set by the stage handoff
// each stage moves on when its successor is empty or advancing, so a stalled
//    rsp_tready fills the pipeline up to four words before req_tready drops;
//    nothing is lost or repeated across a stall
// reset (synchronous, active high) empties all stages; there is no other
//    state, so req_tready is already high when reset falls
module ldpc_check_node_min_sum
   import cnm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DataWidth-1:0] req_tdata,  // in_msg_0 .. in_msg_11, 8 bits each
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DataWidth-1:0] rsp_tdata   // out_msg_0 .. out_msg_11, 8 bits each
);

   msg_type [MsgCount-1:0] in_msg;
   msg_type [MsgCount-1:0] out_msg;

   logic         scale_valid;
   logic         scale_ready;
   edge_set_type scale_set;

   logic         merge_valid;
   logic         merge_ready;
   node_type     merge_node;

   assign in_msg    = req_tdata;
   assign rsp_tdata = out_msg;

   // stage 1: sign split and magnitude scaling
   cnm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_msg    (in_msg),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_set   (scale_set)
   );

   // stages 2 and 3: sort-and-merge tree for min1 and min2, sign parity
   cnm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_ready  (scale_ready),
      .in_set    (scale_set),
      .out_valid (merge_valid),
      .out_ready (merge_ready),
      .out_node  (merge_node)
   );

   // stage 4: per-edge min select and sign, output register
   cnm_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (merge_valid),
      .in_ready  (merge_ready),
      .in_node   (merge_node),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_msg   (out_msg)
   );

`ifndef ASSERT_OFF
   // input back-pressure only ever comes from a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled rsp word");

   // merge tree keeps the two minima ordered
   assert property (@(posedge clock) disable iff (reset)
      merge_valid |-> (merge_node.mins.min1 <= merge_node.mins.min2))
      else $error("min1 above min2");

   // no minimum exceeds the scaled saturation value
   assert property (@(posedge clock) disable iff (reset)
      merge_valid |-> (merge_node.mins.min2 <= MagSat))
      else $error("minimum beyond scaled range");

   // a word held in the merge stage moves on once the select stage frees up
   assert property (@(posedge clock) disable iff (reset)
      (merge_valid && !rsp_tvalid) |=> rsp_tvalid)
      else $error("merged word not passed to output");
`endif

endmodule
